// ===== hw/rtl/pal_pkg.sv =====
// shared command codes, status codes and cell control type for the array list
`default_nettype none
package pal_pkg;

	// command codes
	localparam logic [2:0] CMD_INSERT   = 3'd0;
	localparam logic [2:0] CMD_DELETE   = 3'd1;
	localparam logic [2:0] CMD_LOCATE   = 3'd2;
	localparam logic [2:0] CMD_LOC_RNG  = 3'd3;
	localparam logic [2:0] CMD_RETRIEVE = 3'd4;
	localparam logic [2:0] CMD_CLEAR    = 3'd5;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_RANGE    = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	// highest index a locate can report
	localparam logic [5:0] LAST_INDEX = 6'd63;

	// capacity_limit reset value
	localparam logic [6:0] CAP_LIMIT_RST = 7'd64;

	// control broadcast to every cell when an item is taken
	typedef struct packed {
		logic        do_ins;
		logic        do_del;
		logic        do_srch;
		logic        do_read;
		logic [31:0] value;
		logic [5:0]  pos;
		logic [5:0]  lo;
		logic [5:0]  hi;
	} pal_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pal_cell.sv =====
// one list cell: holds an entry, shifts with its neighbors, flags matches
`default_nettype none
module pal_cell #(
	parameter int IW = 6
) (
	input  wire logic            clk,
	input  wire logic            capture,
	input  wire pal_pkg::pal_ctl_t ctl,
	input  wire logic [IW-1:0]   idx,
	input  wire logic [31:0]     left_entry,
	input  wire logic [31:0]     right_entry,
	output logic      [31:0]     entry,
	output logic                 hit,
	output logic      [31:0]     rdata
);

	localparam int XW = (IW > 6) ? IW : 6;

	logic [31:0] entry_q;
	logic        hit_q;
	logic [31:0] rdata_q;
	logic [XW-1:0] idx_x, pos_x, lo_x, hi_x;

	assign idx_x = XW'(idx);
	assign pos_x = XW'(ctl.pos);
	assign lo_x  = XW'(ctl.lo);
	assign hi_x  = XW'(ctl.hi);

	always_ff @(posedge clk) begin
		if (capture) begin
			if (ctl.do_ins) begin
				if (idx_x > pos_x) begin
					entry_q <= left_entry;
				end else if (idx_x == pos_x) begin
					entry_q <= ctl.value;
				end
			end else if (ctl.do_del) begin
				if (idx_x >= pos_x) begin
					entry_q <= right_entry;
				end
			end
			hit_q   <= ctl.do_srch && (entry_q == ctl.value) && (idx_x >= lo_x)
				&& (idx_x <= hi_x);
			rdata_q <= (ctl.do_read && (idx_x == pos_x)) ? entry_q : 32'd0;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;
	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/positional_array_list.sv =====
// top level of the positional array list: cell chain, match scan and control
`default_nettype none
// positional array list: an ordered list of signed 32-bit values in a row of
// CAP cells. one item carries a command (insert, delete, locate, locate in
// range, retrieve, clear) and gives exactly one result item with status,
// found index, read value and the entry count after the command.
// input channel: in_valid / in_stall with cmd, value, position, range_end.
// output channel: out_valid / out_stall with status, found_index,
// read_value, item_count. capacity_limit is written through the apb port.
// the accept edge shifts the cell chain and latches per-cell match and read
// flags, the scan state then goes over those flags in two halves (priority
// pick plus or of the read words), and the done state loads the output
// register. no new item is taken until the last one leaves the done state.
// the output register holds a result while out_stall is high; the next item
// is still accepted and worked on, and waits in the done state until the
// output register is free.
// reset clears the entry count, the control state and the output valid, and
// sets capacity_limit to 64. entry contents are not cleared.
module positional_array_list #(
	parameter int CAP = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic [31:0] value,
	input  wire logic [5:0]  position,
	input  wire logic [5:0]  range_end,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  status,
	output logic      [5:0]  found_index,
	output logic      [31:0] read_value,
	output logic      [6:0]  item_count,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	// index width of a cell and width of the entry count
	localparam int IW   = $clog2(CAP);
	localparam int CW   = $clog2(CAP + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	// only indexes 0..63 can ever be searched or read
	localparam int SW   = (CAP < 64) ? CAP : 64;
	// the scanned flags are split in two halves
	localparam int CH   = (SW + 1) / 2;
	localparam int PADW = 2 * CH;
	localparam int PW   = (CH > 1) ? $clog2(CH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	// configuration register
	logic [6:0] cap_limit_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {25'd0, cap_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_limit_q <= pal_pkg::CAP_LIMIT_RST;
		end else if (cfg_wr) begin
			cap_limit_q <= pwdata[6:0];
		end
	end

	// command decode at accept
	logic              accept;
	logic [CW-1:0]     count_q;
	logic [CMPW-1:0]   cnt_x, cnt_m1, pos_x, rend_x, cap_x, lim_x;
	pal_pkg::pal_ctl_t ctl;
	logic [1:0]        st_d;
	logic [CW-1:0]     count_d;
	logic              is_loc_d;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign cnt_x  = CMPW'(count_q);
	assign cnt_m1 = cnt_x - CMPW'(1);
	assign pos_x  = CMPW'(position);
	assign rend_x = CMPW'(range_end);
	assign cap_x  = CMPW'(cap_limit_q);
	assign lim_x  = (cap_x < CMPW'(CAP)) ? cap_x : CMPW'(CAP);

	always_comb begin
		ctl.do_ins  = 1'b0;
		ctl.do_del  = 1'b0;
		ctl.do_srch = 1'b0;
		ctl.do_read = 1'b0;
		ctl.value   = value;
		ctl.pos     = position;
		ctl.lo      = 6'd0;
		ctl.hi      = 6'd0;
		st_d        = pal_pkg::STAT_OK;
		count_d     = count_q;
		is_loc_d    = 1'b0;
		unique case (cmd)
			pal_pkg::CMD_INSERT: begin
				if (cnt_x >= lim_x) begin
					st_d = pal_pkg::STAT_FULL;
				end else if (pos_x > cnt_x) begin
					st_d = pal_pkg::STAT_RANGE;
				end else begin
					ctl.do_ins = 1'b1;
					count_d    = count_q + CW'(1);
				end
			end
			pal_pkg::CMD_DELETE: begin
				if (pos_x >= cnt_x) begin
					st_d = pal_pkg::STAT_RANGE;
				end else begin
					ctl.do_del = 1'b1;
					count_d    = count_q - CW'(1);
				end
			end
			pal_pkg::CMD_LOCATE: begin
				is_loc_d    = 1'b1;
				ctl.do_srch = (cnt_x != '0);
				ctl.lo      = 6'd0;
				ctl.hi      = (cnt_m1 > CMPW'(pal_pkg::LAST_INDEX)) ? pal_pkg::LAST_INDEX
					: cnt_m1[5:0];
			end
			pal_pkg::CMD_LOC_RNG: begin
				is_loc_d    = 1'b1;
				ctl.lo      = position;
				ctl.hi      = (rend_x < cnt_m1) ? range_end : cnt_m1[5:0];
				// empty list or start past the clamped end finds nothing
				ctl.do_srch = (cnt_x != '0) && (position <= ctl.hi);
			end
			pal_pkg::CMD_RETRIEVE: begin
				if (pos_x >= cnt_x) begin
					st_d = pal_pkg::STAT_RANGE;
				end else begin
					ctl.do_read = 1'b1;
				end
			end
			pal_pkg::CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
				// unused commands change nothing
			end
		endcase
	end

	// cell chain
	logic [31:0] ent   [CAP];
	logic        hit   [CAP];
	logic [31:0] rdata [CAP];

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [31:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = 32'd0;
		end else begin : g_mid_l
			assign left_w = ent[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign right_w = 32'd0;
		end else begin : g_mid_r
			assign right_w = ent[i+1];
		end
		pal_cell #(
			.IW (IW)
		) u_cell (
			.clk         (clk),
			.capture     (accept),
			.ctl         (ctl),
			.idx         (IW'(i)),
			.left_entry  (left_w),
			.right_entry (right_w),
			.entry       (ent[i]),
			.hit         (hit[i]),
			.rdata       (rdata[i])
		);
	end

	// flags of the searchable cells, padded to two equal halves
	logic [1:0][CH-1:0] hit_half;
	logic [31:0]        rd_half [2][CH];

	for (genvar j = 0; j < PADW; j++) begin : g_pad
		if (j < SW) begin : g_used
			assign hit_half[j / CH][j % CH] = hit[j];
			assign rd_half[j / CH][j % CH]  = rdata[j];
		end else begin : g_fill
			assign hit_half[j / CH][j % CH] = 1'b0;
			assign rd_half[j / CH][j % CH]  = 32'd0;
		end
	end

	// scan of one half per cycle
	logic          half_q;
	logic [CH-1:0] hit_sel;
	logic [PW-1:0] pick;
	logic [31:0]   rd_or;

	assign hit_sel = hit_half[half_q];

	always_comb begin
		pick  = '0;
		rd_or = 32'd0;
		// lowest set flag wins
		for (int k = CH - 1; k >= 0; k--) begin
			if (hit_sel[k]) begin
				pick = PW'(k);
			end
		end
		for (int k = 0; k < CH; k++) begin
			rd_or = rd_or | rd_half[half_q][k];
		end
	end

	// pending result
	logic [1:0]  st_q;
	logic        is_loc_q;
	logic        found_q;
	logic [5:0]  fidx_q;
	logic [31:0] rval_q;
	logic        out_free;

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			half_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= count_d;
						half_q  <= 1'b0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!found_q && (hit_sel != '0)) begin
						found_q <= 1'b1;
					end
					half_q <= 1'b1;
					if (half_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			st_q     <= st_d;
			is_loc_q <= is_loc_d;
			fidx_q   <= 6'd0;
			rval_q   <= 32'd0;
		end else if (state_q == ST_SCAN) begin
			if (!found_q && (hit_sel != '0)) begin
				fidx_q <= 6'(int'(half_q) * CH + int'(pick));
			end
			rval_q <= rval_q | rd_or;
		end
	end

	// output register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [5:0]  found_index_q;
	logic [31:0] read_value_q;
	logic [6:0]  item_count_q;
	logic        load;

	assign load = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q      <= (is_loc_q && !found_q) ? pal_pkg::STAT_NOTFOUND : st_q;
			found_index_q <= fidx_q;
			read_value_q  <= rval_q;
			item_count_q  <= 7'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign read_value  = read_value_q;
	assign item_count  = item_count_q;

endmodule
`default_nettype wire
